// ===== hdl/psl_pkg.sv =====
// ----------------------------------------------------------------------------
// psl_pkg
// Shared types and constants of the packet statistics line parser.
// ----------------------------------------------------------------------------
package psl_pkg;

  localparam int unsigned LINE_COUNT_BITS_DEF = 32;
  // result queue places, a power of two and at least two
  localparam int unsigned QUEUE_DEPTH_DEF     = 4;

  // character codes
  localparam logic [7:0] CH_NEWLINE = 8'd10;
  localparam logic [7:0] CH_SPACE   = 8'd32;
  localparam logic [7:0] CH_TAB     = 8'd9;
  localparam logic [7:0] CH_VTAB    = 8'd11;
  localparam logic [7:0] CH_FFEED   = 8'd12;
  localparam logic [7:0] CH_CRET    = 8'd13;
  localparam logic [7:0] CH_ZERO    = 8'd48;
  localparam logic [7:0] CH_NINE    = 8'd57;
  localparam logic [7:0] CH_P       = 8'd80;
  localparam logic [7:0] CH_POINT   = 8'd46;
  localparam logic [7:0] CH_COLON   = 8'd58;

  // value limits
  localparam logic [19:0] LIMIT_U16 = 20'd65535;
  localparam logic [19:0] LIMIT_U8  = 20'd255;

  // input transaction kinds
  localparam logic KIND_BYTE = 1'b0;
  localparam logic KIND_END  = 1'b1;

  typedef enum logic [2:0] {
    ST_RECORD    = 3'd0,
    ST_END       = 3'd1,
    ST_SHORT     = 3'd2,
    ST_BAD_CHAR  = 3'd3,
    ST_OVERFLOW  = 3'd4
  } status_t;

  // line phases, the four octet phases must stay consecutive
  typedef enum logic [3:0] {
    PH_START = 4'd0,
    PH_SKIP  = 4'd1,
    PH_LEAD  = 4'd2,
    PH_PKT   = 4'd3,
    PH_B1    = 4'd4,
    PH_TINT  = 4'd5,
    PH_TFRAC = 4'd6,
    PH_B2    = 4'd7,
    PH_LEN   = 4'd8,
    PH_B3    = 4'd9,
    PH_OCT0  = 4'd10,
    PH_OCT1  = 4'd11,
    PH_OCT2  = 4'd12,
    PH_OCT3  = 4'd13,
    PH_PORT  = 4'd14,
    PH_TAIL  = 4'd15
  } phase_t;

  typedef struct packed {
    status_t     status;
    logic [15:0] packet_length;
    logic [7:0]  octet_first;
    logic [7:0]  octet_second;
    logic [7:0]  octet_third;
    logic [7:0]  octet_fourth;
    logic [15:0] source_port;
    logic [31:0] line_number;
    logic        last_of_run;
  } res_t;

  // results produced by one input transaction, second only with the first
  typedef struct packed {
    logic r0_v;
    logic r1_v;
    res_t r0;
    res_t r1;
  } push_t;

endpackage

// ===== hdl/psl_if.sv =====
// ----------------------------------------------------------------------------
// psl_in_if / psl_out_if
// Valid/ready channels carrying input bytes and parser results.
// ----------------------------------------------------------------------------
interface psl_in_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [7:0] text_byte;

  modport source (output valid, output kind, output text_byte, input ready);
  modport sink (input valid, input kind, input text_byte, output ready);
endinterface

interface psl_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [15:0] packet_length;
  logic [7:0]  octet_first;
  logic [7:0]  octet_second;
  logic [7:0]  octet_third;
  logic [7:0]  octet_fourth;
  logic [15:0] source_port;
  logic [31:0] line_number;
  logic        last_of_run;

  modport source (output valid, output status, output packet_length,
                  output octet_first, output octet_second, output octet_third,
                  output octet_fourth, output source_port, output line_number,
                  output last_of_run, input ready);
  modport sink (input valid, input status, input packet_length,
                input octet_first, input octet_second, input octet_third,
                input octet_fourth, input source_port, input line_number,
                input last_of_run, output ready);
endinterface

// ===== hdl/psl_core.sv =====
// ----------------------------------------------------------------------------
// psl_core
// Per-byte parser state machine: phase, number accumulator, stored fields,
// line counter and sticky stop flag. Emits up to two results per transaction.
// ----------------------------------------------------------------------------
module psl_core
  import psl_pkg::*;
#(
  parameter int unsigned LINE_COUNT_BITS = LINE_COUNT_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       accept,
  input  logic       in_kind,
  input  logic [7:0] in_byte,
  output push_t      push
);

  phase_t                     phase_r, phase_nxt;
  logic [15:0]                acc_r, acc_nxt;
  logic [3:0][7:0]            oct_r, oct_nxt;
  logic [15:0]                len_r, len_nxt;
  logic [LINE_COUNT_BITS-1:0] cnt_r, cnt_nxt;
  logic                       stop_r, stop_nxt;

  // character classes
  logic        is_dig, is_blank, is_nl;
  logic [3:0]  dval;
  logic [19:0] acc_x10;
  logic        ovf16, ovf8;
  logic        cnt_bump;
  logic [31:0] line_no;
  res_t        rec_res, nul_res;
  logic [1:0]  oct_idx;
  logic [7:0]  delim;

  assign is_dig   = (in_byte >= CH_ZERO) && (in_byte <= CH_NINE);
  assign is_blank = (in_byte == CH_SPACE) || (in_byte == CH_TAB) || (in_byte == CH_VTAB)
                    || (in_byte == CH_FFEED) || (in_byte == CH_CRET);
  assign is_nl    = (in_byte == CH_NEWLINE);
  assign dval     = in_byte[3:0] - CH_ZERO[3:0];

  // accumulator times ten plus the new digit
  assign acc_x10 = ({4'd0, acc_r} << 3) + ({4'd0, acc_r} << 1) + {16'd0, dval};
  assign ovf16   = acc_x10 > LIMIT_U16;
  assign ovf8    = acc_x10 > LIMIT_U8;

  // line counted at its first byte, saturating
  assign cnt_bump = accept && !stop_r && (in_kind == KIND_BYTE) && (phase_r == PH_START)
                    && (cnt_r != {LINE_COUNT_BITS{1'b1}});
  assign line_no  = 32'(cnt_bump ? cnt_r + 1'b1 : cnt_r);

  assign oct_idx = 2'(4'(phase_r) - 4'(PH_OCT0));
  assign delim   = (oct_idx == 2'd3) ? CH_COLON : CH_POINT;

  // result templates
  always_comb begin
    rec_res               = '0;
    rec_res.status        = ST_RECORD;
    rec_res.packet_length = len_r;
    rec_res.octet_first   = oct_r[0];
    rec_res.octet_second  = oct_r[1];
    rec_res.octet_third   = oct_r[2];
    rec_res.octet_fourth  = oct_r[3];
    rec_res.source_port   = acc_r;
    rec_res.line_number   = line_no;
    nul_res               = '0;
    nul_res.status        = ST_END;
    nul_res.line_number   = line_no;
  end

  // next state and results
  always_comb begin
    phase_nxt = phase_r;
    acc_nxt   = acc_r;
    oct_nxt   = oct_r;
    len_nxt   = len_r;
    cnt_nxt   = cnt_bump ? cnt_r + 1'b1 : cnt_r;
    stop_nxt  = stop_r;
    push      = '0;
    push.r0   = nul_res;
    push.r1   = nul_res;
    push.r0.last_of_run = 1'b1;
    push.r1.last_of_run = 1'b1;

    if (accept && !stop_r) begin
      if (in_kind == KIND_END || is_nl) begin
        // line end: finish any pending P line
        if (phase_r == PH_PORT || phase_r == PH_TAIL) begin
          push.r0_v = 1'b1;
          push.r0   = rec_res;
          phase_nxt = PH_START;
          if (in_kind == KIND_END) begin
            push.r1_v = 1'b1;
            stop_nxt  = 1'b1;
          end else begin
            push.r0.last_of_run = 1'b1;
          end
        end else if (phase_r == PH_START || phase_r == PH_SKIP) begin
          phase_nxt = PH_START;
          if (in_kind == KIND_END) begin
            push.r0_v = 1'b1;
            stop_nxt  = 1'b1;
          end
        end else begin
          push.r0_v      = 1'b1;
          push.r0.status = ST_SHORT;
          stop_nxt       = 1'b1;
        end
      end else begin
        case (phase_r)
          PH_START: phase_nxt = (in_byte == CH_P) ? PH_LEAD : PH_SKIP;
          PH_SKIP: ;
          PH_LEAD: begin
            if (is_dig) phase_nxt = PH_PKT;
            else if (!is_blank) push.r0_v = 1'b1;
          end
          PH_PKT: begin
            if (is_blank) phase_nxt = PH_B1;
            else if (!is_dig) push.r0_v = 1'b1;
          end
          PH_B1: begin
            if (is_dig) phase_nxt = PH_TINT;
            else if (!is_blank) push.r0_v = 1'b1;
          end
          PH_TINT: begin
            if (in_byte == CH_POINT) phase_nxt = PH_TFRAC;
            else if (!is_dig) push.r0_v = 1'b1;
          end
          PH_TFRAC: begin
            if (is_blank) phase_nxt = PH_B2;
            else if (!is_dig) push.r0_v = 1'b1;
          end
          PH_B2, PH_B3: begin
            if (is_dig) begin
              acc_nxt   = {12'd0, dval};
              phase_nxt = (phase_r == PH_B2) ? PH_LEN : PH_OCT0;
            end else if (!is_blank) begin
              push.r0_v = 1'b1;
            end
          end
          PH_LEN, PH_PORT: begin
            if (is_dig) begin
              if (ovf16) begin
                push.r0_v      = 1'b1;
                push.r0.status = ST_OVERFLOW;
              end else begin
                acc_nxt = acc_x10[15:0];
              end
            end else if (is_blank) begin
              if (phase_r == PH_LEN) begin
                len_nxt   = acc_r;
                phase_nxt = PH_B3;
              end else begin
                phase_nxt = PH_TAIL;
              end
            end else begin
              push.r0_v = 1'b1;
            end
          end
          PH_OCT0, PH_OCT1, PH_OCT2, PH_OCT3: begin
            if (is_dig) begin
              if (ovf8) begin
                push.r0_v      = 1'b1;
                push.r0.status = ST_OVERFLOW;
              end else begin
                acc_nxt = acc_x10[15:0];
              end
            end else if (in_byte == delim) begin
              oct_nxt[oct_idx] = acc_r[7:0];
              acc_nxt          = '0;
              phase_nxt        = phase_t'(4'(phase_r) + 4'd1);
            end else begin
              push.r0_v = 1'b1;
            end
          end
          PH_TAIL: begin
            if (!is_blank) push.r0_v = 1'b1;
          end
          default: ;
        endcase
        // any result from a plain byte is an error
        if (push.r0_v) begin
          stop_nxt = 1'b1;
          if (push.r0.status == ST_END) push.r0.status = ST_BAD_CHAR;
        end
      end
      if (push.r1_v) push.r0.last_of_run = 1'b0;
    end
  end

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_START;
      acc_r   <= '0;
      oct_r   <= '0;
      len_r   <= '0;
      cnt_r   <= '0;
      stop_r  <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      acc_r   <= acc_nxt;
      oct_r   <= oct_nxt;
      len_r   <= len_nxt;
      cnt_r   <= cnt_nxt;
      stop_r  <= stop_nxt;
    end
  end

  // once stopped, the parser stays stopped until reset
  a_stop_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    stop_r |=> stop_r)
    else $error("stop flag cleared without reset");

  // a stopped parser produces nothing
  a_silent_stopped: assert property (@(posedge clk) disable iff (!rst_n)
    stop_r |-> !push.r0_v)
    else $error("result produced while stopped");

  // a second result is always the end mark following a record
  a_second_is_end: assert property (@(posedge clk) disable iff (!rst_n)
    push.r1_v |-> (push.r0_v && push.r0.status == ST_RECORD && push.r1.status == ST_END
                   && stop_nxt))
    else $error("malformed pair of results");

  // every result transaction ends its run on the last result
  a_last_marked: assert property (@(posedge clk) disable iff (!rst_n)
    (push.r0_v && !push.r1_v) |-> push.r0.last_of_run)
    else $error("single result not marked last");

endmodule

// ===== hdl/psl_queue.sv =====
// ----------------------------------------------------------------------------
// psl_queue
// Small result queue decoupling the parser from the output channel; takes
// one or two results per cycle and hands out one per cycle while out_ready is high.
// ----------------------------------------------------------------------------
module psl_queue
  import psl_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  push_t push,
  output logic  room,
  output logic  out_valid,
  input  logic  out_ready,
  output res_t  out_res
);

  localparam int unsigned DEPTH = QUEUE_DEPTH_DEF;
  localparam int unsigned PW    = $clog2(DEPTH);
  localparam int unsigned CW    = $clog2(DEPTH + 1);

  res_t          mem_r [DEPTH];
  logic [PW-1:0] wptr_r, wptr_nxt, rptr_r, rptr_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          pop;
  logic [1:0]    n_push;
  logic [PW-1:0] wptr_p1;

  assign out_valid = (cnt_r != '0);
  assign out_res   = mem_r[rptr_r];
  assign room      = (cnt_r <= CW'(DEPTH - 2));
  assign pop       = out_valid && out_ready;
  assign n_push    = {1'b0, push.r0_v} + {1'b0, push.r1_v};
  assign wptr_p1   = PW'(wptr_r + 1'b1);

  // pointer and fill level update
  always_comb begin
    wptr_nxt = PW'(wptr_r + PW'(n_push));
    rptr_nxt = pop ? PW'(rptr_r + 1'b1) : rptr_r;
    cnt_nxt  = CW'(cnt_r + CW'(n_push) - CW'(pop));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // result storage
  always_ff @(posedge clk) begin
    if (push.r0_v) mem_r[wptr_r] <= push.r0;
    if (push.r1_v) mem_r[wptr_p1] <= push.r1;
  end

  // fill level never passes the depth
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(DEPTH))
    else $error("result queue overrun");

  // results only arrive when two places are free
  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    push.r0_v |-> room)
    else $error("results pushed without room");

  // a pop with no push lowers the fill level by one
  a_pop_level: assert property (@(posedge clk) disable iff (!rst_n)
    (pop && !push.r0_v && !push.r1_v) |=> (cnt_r == CW'($past(cnt_r) - 1'b1)))
    else $error("fill level wrong after pop");

endmodule

// ===== hdl/packet_stat_line_parser.sv =====
// ----------------------------------------------------------------------------
// packet_stat_line_parser
// Parses packet statistics text lines into records of length, address and
// port, with sticky error and end-of-input reporting.
// ----------------------------------------------------------------------------
// One input transaction is taken per clock cycle: each byte goes through a
// single registered parser step (one compare set and one multiply by ten on
// a 16-bit accumulator) and its results go into a four-entry result queue.
// in_chan.ready drops only while fewer than two queue places are free, so
// with the output side always ready the block runs at one byte per cycle;
// a byte's first result is written into the queue at the edge that accepts
// the byte and is offered on out_chan in the very next cycle. The end
// mark may give two results (a pending record, then the end status); after
// the end mark or the first error every further transaction is consumed
// without result until reset. line_number counts lines in a saturating
// counter LINE_COUNT_BITS wide, shown in its low 32 bits.
// ----------------------------------------------------------------------------
module packet_stat_line_parser
  import psl_pkg::*;
#(
  parameter int unsigned LINE_COUNT_BITS = LINE_COUNT_BITS_DEF
) (
  input logic       clk,
  input logic       rst_n,
  psl_in_if.sink    in_chan,
  psl_out_if.source out_chan
);

  push_t push;
  logic  room;
  logic  accept;
  res_t  res;

  // input handshake
  assign in_chan.ready = room;
  assign accept        = in_chan.valid && room;

  psl_core #(
    .LINE_COUNT_BITS(LINE_COUNT_BITS)
  ) u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .accept  (accept),
    .in_kind (in_chan.kind),
    .in_byte (in_chan.text_byte),
    .push    (push)
  );

  psl_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .room      (room),
    .out_valid (out_chan.valid),
    .out_ready (out_chan.ready),
    .out_res   (res)
  );

  // result payload
  assign out_chan.status        = res.status;
  assign out_chan.packet_length = res.packet_length;
  assign out_chan.octet_first   = res.octet_first;
  assign out_chan.octet_second  = res.octet_second;
  assign out_chan.octet_third   = res.octet_third;
  assign out_chan.octet_fourth  = res.octet_fourth;
  assign out_chan.source_port   = res.source_port;
  assign out_chan.line_number   = res.line_number;
  assign out_chan.last_of_run   = res.last_of_run;

endmodule
